FILE: design/ptts_pkg.sv
// Shared types and constants of the periodic task tick scheduler.
`default_nettype none
package ptts_pkg;

  localparam int NUM_TASKS_DEF = 8;

  // Most fire transfers that one tick reports.
  localparam int RES_MAX = 8;
  localparam int FIRE_CNT_W = 4;

  // Command queue between front and back.
  localparam int CMD_Q_DEPTH = 2;
  localparam int CMD_Q_PW = 1;
  localparam int CMD_Q_CW = 2;

  localparam int OP_W = 3;
  localparam int SLOT_W = 8;
  localparam int TIME_W = 8;
  localparam int FIRED_W = 6;

  typedef enum logic [OP_W-1:0] {
    OP_TICK    = 3'd0,
    OP_CREATE  = 3'd1,
    OP_DELETE  = 3'd2,
    OP_SUSPEND = 3'd3,
    OP_RESUME  = 3'd4
  } op_e;

  localparam logic [1:0] ST_DONE     = 2'd0;
  localparam logic [1:0] ST_RANGE    = 2'd1;
  localparam logic [1:0] ST_OCCUPIED = 2'd2;

  localparam logic KIND_STATUS = 1'b0;
  localparam logic KIND_FIRE   = 1'b1;

  typedef struct packed {
    op_e                op;
    logic               in_range;
    logic [SLOT_W-1:0]  slot;
    logic [TIME_W-1:0]  period;
    logic [TIME_W-1:0]  first_delay;
  } cmd_t;

endpackage
`default_nettype wire

FILE: design/periodic_task_tick_scheduler.sv
// Top level of the periodic task tick scheduler.
//
//  channel  | dir | tdata (low bit up)                         | tuser | tlast
//  s_axis   | in  | slot[7:0] period[15:8] first_delay[23:16]  | op    | -
//  m_axis   | out | status[1:0] fired_slot[7:2]                | kind  | last
//
// A create, delete, suspend or resume is applied in the back end as it leaves
// the two-entry command queue. A tick walks the slot table through the
// period/countdown memory read port, one slot per cycle unless a result
// waits on the output. Reset empties the table and the queue. A stalled output
// holds creates and tick results; the front takes items until the queue fills.
`default_nettype none
module periodic_task_tick_scheduler
  import ptts_pkg::*;
#(
  parameter int NUM_TASKS = NUM_TASKS_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [23:0] s_axis_tdata_i,   // slot, period, first_delay
  input  wire logic [2:0]  s_axis_tuser_i,   // op
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [7:0]       m_axis_tdata_o,   // status, fired_slot
  output logic [0:0]       m_axis_tuser_o,   // kind
  output logic             m_axis_tlast_o
);

  logic               q_push;
  logic               q_full;
  logic               q_pop;
  logic               q_valid;
  cmd_t               push_cmd;
  cmd_t               pop_cmd;
  logic               kind;
  logic [1:0]         status;
  logic [FIRED_W-1:0] fired_slot;

  ptts_front #(
    .NUM_TASKS(NUM_TASKS)
  ) u_front (
    .s_valid_i    (s_axis_tvalid_i),
    .s_ready_o    (s_axis_tready_o),
    .op_i         (s_axis_tuser_i),
    .slot_i       (s_axis_tdata_i[7:0]),
    .period_i     (s_axis_tdata_i[15:8]),
    .first_delay_i(s_axis_tdata_i[23:16]),
    .q_full_i     (q_full),
    .q_push_o     (q_push),
    .q_cmd_o      (push_cmd)
  );

  ptts_cmd_fifo u_cmd_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (q_push),
    .push_cmd_i(push_cmd),
    .full_o    (q_full),
    .pop_i     (q_pop),
    .valid_o   (q_valid),
    .pop_cmd_o (pop_cmd)
  );

  ptts_back #(
    .NUM_TASKS(NUM_TASKS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_cmd_i     (pop_cmd),
    .q_pop_o     (q_pop),
    .m_valid_o   (m_axis_tvalid_o),
    .m_ready_i   (m_axis_tready_i),
    .kind_o      (kind),
    .status_o    (status),
    .fired_slot_o(fired_slot),
    .last_o      (m_axis_tlast_o)
  );

  assign m_axis_tdata_o = {fired_slot, status};
  assign m_axis_tuser_o = kind;

endmodule
`default_nettype wire

FILE: design/ptts_front.sv
// Front end: accepts input transfers, decodes and filters them into commands.
`default_nettype none
module ptts_front
  import ptts_pkg::*;
#(
  parameter int NUM_TASKS = NUM_TASKS_DEF
) (
  input  wire logic               s_valid_i,
  output logic                    s_ready_o,
  input  wire logic [OP_W-1:0]    op_i,
  input  wire logic [SLOT_W-1:0]  slot_i,
  input  wire logic [TIME_W-1:0]  period_i,
  input  wire logic [TIME_W-1:0]  first_delay_i,
  input  wire logic               q_full_i,
  output logic                    q_push_o,
  output cmd_t                    q_cmd_o
);

  localparam logic [SLOT_W-1:0] NumTasksW = SLOT_W'(NUM_TASKS);

  logic in_range;
  logic keep;

  always_comb begin
    in_range = (slot_i < NumTasksW);
    q_cmd_o.op          = op_e'(op_i);
    q_cmd_o.in_range    = in_range;
    q_cmd_o.slot        = slot_i;
    q_cmd_o.period      = period_i;
    q_cmd_o.first_delay = first_delay_i;
    // Drop unused codes and delete, suspend or resume commands that address no slot.
    case (op_e'(op_i))
      OP_TICK:    keep = 1'b1;
      OP_CREATE:  keep = 1'b1;
      OP_DELETE:  keep = in_range;
      OP_SUSPEND: keep = in_range;
      OP_RESUME:  keep = in_range;
      default:    keep = 1'b0;
    endcase
  end

  assign s_ready_o = !q_full_i;
  assign q_push_o  = s_valid_i && !q_full_i && keep;

endmodule
`default_nettype wire

FILE: design/ptts_cmd_fifo.sv
// Short command queue between front and back.
`default_nettype none
module ptts_cmd_fifo
  import ptts_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire cmd_t push_cmd_i,
  output logic      full_o,
  input  wire logic pop_i,
  output logic      valid_o,
  output cmd_t      pop_cmd_o
);

  cmd_t                entry_q [CMD_Q_DEPTH];
  logic [CMD_Q_PW-1:0] wr_ptr_q, wr_ptr_d;
  logic [CMD_Q_PW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CMD_Q_CW-1:0] count_q, count_d;

  assign full_o    = (count_q == CMD_Q_CW'(CMD_Q_DEPTH));
  assign valid_o   = (count_q != '0);
  assign pop_cmd_o = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop_i ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule
`default_nettype wire

FILE: design/ptts_back.sv
// Back end: slot table, slot command handling, tick walk and result register.
`default_nettype none
module ptts_back
  import ptts_pkg::*;
#(
  parameter int NUM_TASKS = NUM_TASKS_DEF
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               q_valid_i,
  input  wire cmd_t               q_cmd_i,
  output logic                    q_pop_o,
  output logic                    m_valid_o,
  input  wire logic               m_ready_i,
  output logic                    kind_o,
  output logic [1:0]              status_o,
  output logic [FIRED_W-1:0]      fired_slot_o,
  output logic                    last_o
);

  localparam int IW = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
  localparam logic [IW-1:0] LastIdx = IW'(NUM_TASKS - 1);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_WALK  = 2'd1;
  localparam logic [1:0] S_FLUSH = 2'd2;

  logic [1:0]            state_q, state_d;
  logic [NUM_TASKS-1:0]  occ_q, occ_d;
  logic [NUM_TASKS-1:0]  sus_q, sus_d;

  logic [TIME_W-1:0]     per_mem [NUM_TASKS];
  logic [TIME_W-1:0]     cd_mem  [NUM_TASKS];
  logic [TIME_W-1:0]     per_rd_q;
  logic [TIME_W-1:0]     cd_rd_q;

  logic [IW-1:0]         rd_idx_q, rd_idx_d;
  logic                  issue_q, issue_d;
  logic [IW-1:0]         p_idx_q, p_idx_d;
  logic                  p_valid_q, p_valid_d;
  logic [FIRE_CNT_W-1:0] fire_cnt_q, fire_cnt_d;
  logic                  pend_valid_q, pend_valid_d;
  logic [FIRED_W-1:0]    pend_slot_q, pend_slot_d;

  logic                  out_valid_q;
  logic                  out_kind_q;
  logic [1:0]            out_status_q;
  logic [FIRED_W-1:0]    out_slot_q;
  logic                  out_last_q;

  logic                  out_ready;
  logic [IW-1:0]         s_idx;
  logic                  p_elig, p_fire, p_report, need_emit, stall;
  logic                  rd_en;
  logic                  cd_we, per_we;
  logic [IW-1:0]         cd_waddr;
  logic [TIME_W-1:0]     cd_wdata;
  logic                  emit;
  logic                  e_kind;
  logic [1:0]            e_status;
  logic [FIRED_W-1:0]    e_slot;
  logic                  e_last;

  assign out_ready = !out_valid_q || m_ready_i;
  assign s_idx     = q_cmd_i.slot[IW-1:0];

  always_comb begin
    p_elig    = occ_q[p_idx_q] && !sus_q[p_idx_q];
    p_fire    = p_valid_q && p_elig && (cd_rd_q == '0);
    p_report  = p_fire && (fire_cnt_q < FIRE_CNT_W'(RES_MAX));
    need_emit = p_report && pend_valid_q;
    stall     = need_emit && !out_ready;
  end

  always_comb begin
    state_d      = state_q;
    occ_d        = occ_q;
    sus_d        = sus_q;
    rd_idx_d     = rd_idx_q;
    issue_d      = issue_q;
    p_idx_d      = p_idx_q;
    p_valid_d    = p_valid_q;
    fire_cnt_d   = fire_cnt_q;
    pend_valid_d = pend_valid_q;
    pend_slot_d  = pend_slot_q;
    q_pop_o      = 1'b0;
    rd_en        = 1'b0;
    cd_we        = 1'b0;
    per_we       = 1'b0;
    cd_waddr     = p_idx_q;
    cd_wdata     = (cd_rd_q == '0) ? per_rd_q : cd_rd_q - 1'b1;
    emit         = 1'b0;
    e_kind       = KIND_FIRE;
    e_status     = ST_DONE;
    e_slot       = pend_slot_q;
    e_last       = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (q_valid_i && (q_cmd_i.op != OP_CREATE || out_ready)) begin
          q_pop_o = 1'b1;
          case (q_cmd_i.op)
            OP_TICK: begin
              state_d      = S_WALK;
              rd_idx_d     = '0;
              issue_d      = 1'b1;
              p_valid_d    = 1'b0;
              fire_cnt_d   = '0;
              pend_valid_d = 1'b0;
            end
            OP_CREATE: begin
              emit     = 1'b1;
              e_kind   = KIND_STATUS;
              e_slot   = '0;
              e_last   = 1'b1;
              if (!q_cmd_i.in_range) begin
                e_status = ST_RANGE;
              end else if (occ_q[s_idx]) begin
                e_status = ST_OCCUPIED;
              end else begin
                e_status     = ST_DONE;
                occ_d[s_idx] = 1'b1;
                sus_d[s_idx] = 1'b0;
                per_we       = 1'b1;
                cd_we        = 1'b1;
                cd_waddr     = s_idx;
                cd_wdata     = q_cmd_i.first_delay;
              end
            end
            OP_DELETE: begin
              if (occ_q[s_idx]) begin
                occ_d[s_idx] = 1'b0;
                sus_d[s_idx] = 1'b0;
              end
            end
            OP_SUSPEND: begin
              if (occ_q[s_idx]) begin
                sus_d[s_idx] = 1'b1;
              end
            end
            OP_RESUME: begin
              if (occ_q[s_idx]) begin
                sus_d[s_idx] = 1'b0;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_WALK: begin
        if (!stall) begin
          // Update stage: reload or count down the slot fetched by the read stage.
          if (p_valid_q && p_elig) begin
            cd_we = 1'b1;
          end
          if (need_emit) begin
            emit = 1'b1;
          end
          if (p_report) begin
            fire_cnt_d   = fire_cnt_q + 1'b1;
            pend_valid_d = 1'b1;
            pend_slot_d  = FIRED_W'(p_idx_q);
          end
          // Read stage: fetch the next slot.
          if (issue_q) begin
            rd_en     = 1'b1;
            p_idx_d   = rd_idx_q;
            p_valid_d = 1'b1;
            if (rd_idx_q == LastIdx) begin
              issue_d = 1'b0;
            end else begin
              rd_idx_d = rd_idx_q + 1'b1;
            end
          end else begin
            p_valid_d = 1'b0;
            if (!p_valid_q) begin
              state_d = S_FLUSH;
            end
          end
        end
      end
      S_FLUSH: begin
        if (!pend_valid_q) begin
          state_d = S_IDLE;
        end else if (out_ready) begin
          emit         = 1'b1;
          e_last       = 1'b1;
          pend_valid_d = 1'b0;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      occ_q        <= '0;
      sus_q        <= '0;
      rd_idx_q     <= '0;
      issue_q      <= 1'b0;
      p_idx_q      <= '0;
      p_valid_q    <= 1'b0;
      fire_cnt_q   <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      occ_q        <= occ_d;
      sus_q        <= sus_d;
      rd_idx_q     <= rd_idx_d;
      issue_q      <= issue_d;
      p_idx_q      <= p_idx_d;
      p_valid_q    <= p_valid_d;
      fire_cnt_q   <= fire_cnt_d;
      pend_valid_q <= pend_valid_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (m_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pend_slot_q <= pend_slot_d;
    if (emit) begin
      out_kind_q   <= e_kind;
      out_status_q <= e_status;
      out_slot_q   <= e_slot;
      out_last_q   <= e_last;
    end
  end

  // Slot period and countdown memories: one write port, registered read.
  always_ff @(posedge clk_i) begin
    if (per_we) begin
      per_mem[s_idx] <= q_cmd_i.period;
    end
    if (cd_we) begin
      cd_mem[cd_waddr] <= cd_wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      per_rd_q <= per_mem[rd_idx_q];
      cd_rd_q  <= cd_mem[rd_idx_q];
    end
  end

  assign m_valid_o    = out_valid_q;
  assign kind_o       = out_kind_q;
  assign status_o     = out_status_q;
  assign fired_slot_o = out_slot_q;
  assign last_o       = out_last_q;

endmodule
`default_nettype wire
